[hdl/aes_pkg.sv]
// Package: shared types, constants and GF(2^8) functions for the AES block.
`timescale 1ns / 1ps
package aes_pkg;

	typedef enum logic [2:0] {
		REG_KEY_LENGTH = 3'd0,
		REG_KEY_WORD_0 = 3'd1,
		REG_KEY_WORD_1 = 3'd2,
		REG_KEY_WORD_2 = 3'd3,
		REG_KEY_WORD_3 = 3'd4
	} reg_index_t;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_item_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		logic [7:0] x;
		r = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r = r ^ x;
			x = xtime(x);
		end
		gmul = r;
	endfunction

	function automatic logic [7:0] ginv(input logic [7:0] a);
		logic [7:0] r;
		logic [7:0] base;
		r = 8'h01;
		base = a;
		// a^254: exponent bits 11111110
		for (int i = 0; i < 8; i++) begin
			if (i != 0) r = gmul(r, base);
			base = gmul(base, base);
		end
		ginv = r;
	endfunction

	function automatic logic [7:0] rot8(input logic [7:0] x, input int n);
		rot8 = (x << n) | (x >> (8 - n));
	endfunction

	function automatic logic [7:0] sbox_calc(input logic [7:0] x);
		logic [7:0] y;
		y = ginv(x);
		sbox_calc = y ^ rot8(y, 1) ^ rot8(y, 2) ^ rot8(y, 3) ^ rot8(y, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] inv_sbox_calc(input logic [7:0] x);
		inv_sbox_calc = ginv(rot8(x, 1) ^ rot8(x, 3) ^ rot8(x, 6) ^ 8'h05);
	endfunction

	typedef logic [7:0] sbox_table_t [256];

	function automatic sbox_table_t make_sbox(input logic inverse);
		sbox_table_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = inverse ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
		end
		make_sbox = t;
	endfunction

	localparam sbox_table_t SBOX = make_sbox(1'b0);
	localparam sbox_table_t INV_SBOX = make_sbox(1'b1);

endpackage

[hdl/aes_ram.sv]
// Generic single-port-write RAM with one registered read port.
`timescale 1ns / 1ps
module aes_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[hdl/aes_block_cipher.sv]
// Top level: AES-128/192/256 encrypt and equivalent inverse cipher, byte-serial datapath.
//
// The datapath is byte serial: the 16-byte state moves through a shift register one byte per
// cycle, passing a single key XOR and a single S-box lookup (forward or inverse); ShiftRows
// and MixColumns on all four columns then follow in one mix step. Each round first reads its
// four round key words from RAM, then makes 16 byte steps and the mix step; the last round
// has no mix step. The next block can be transferred in the cycle in which the result first
// shows. After any configuration write the next block first expands the key schedule into
// the round key RAM (64 x 32): each key word is copied in, each derived word is XORed with
// w[i-nk], and SubWord runs byte by byte through the S-box. It then builds the decrypt round
// keys into a second RAM (64 x 32), with InvMixColumns on the middle rounds. Later blocks
// skip both steps until the next configuration write. The next input is taken when the block
// is idle and the result register is empty or being taken in the same cycle.
`timescale 1ns / 1ps
module aes_block_cipher import aes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KX_RD,
		ST_KX_WAIT,
		ST_KX_WR,
		ST_IK_RD,
		ST_IK_WAIT,
		ST_IK_WR,
		ST_KEY_RD,
		ST_KEY_WAIT,
		ST_BYTE,
		ST_MIX,
		ST_DONE
	} state_t;

	state_t      state_q;
	logic [1:0]  key_length_q;
	logic [63:0] key_word_q [4];
	logic        keys_ready_q;
	logic        cmd_q;
	logic [127:0] st_q;       // byte 0 in the top bits; shifts left by one byte
	logic [127:0] rk_q;       // round key bytes, same order
	logic [5:0]  widx_q;      // key schedule word index
	logic [3:0]  round_q;
	logic [4:0]  step_q;      // byte step or key word counter
	logic [7:0]  rcon_q;
	logic [31:0] prev_q;      // last schedule word
	logic [31:0] tmp_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic [1:0]  bsel_q;      // byte of a word in the sub_word pass
	logic [3:0]  nk;
	logic [3:0]  nr;
	logic [5:0]  total;

	// Round key RAM (encrypt schedule) and decrypt key RAM
	logic        ek_we;
	logic [5:0]  ek_waddr, ek_raddr;
	logic [31:0] ek_wdata, ek_rdata;
	logic        dk_we;
	logic [5:0]  dk_waddr, dk_raddr;
	logic [31:0] dk_wdata, dk_rdata;

	aes_ram #(.Width(32), .Depth(64)) u_ek_ram (
		.clk(clk), .we(ek_we), .waddr(ek_waddr), .wdata(ek_wdata),
		.raddr(ek_raddr), .rdata(ek_rdata)
	);
	aes_ram #(.Width(32), .Depth(64)) u_dk_ram (
		.clk(clk), .we(dk_we), .waddr(dk_waddr), .wdata(dk_wdata),
		.raddr(dk_raddr), .rdata(dk_rdata)
	);

	always_comb begin
		case (key_length_q)
			2'd0:    nk = 4'd4;
			2'd1:    nk = 4'd6;
			default: nk = 4'd8;
		endcase
		nr = nk + 4'd6;
		total = {nr, 2'b00} + 6'd4;
	end

	// Key word index modulo nk: small compare chain on a counter kept alongside widx
	logic [3:0] kmod_q;

	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		inv_mix_col = {
			gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9),
			gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13),
			gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11),
			gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14)};
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3, t;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		t = a0 ^ a1 ^ a2 ^ a3;
		mix_col = {a0 ^ t ^ xtime(a0 ^ a1), a1 ^ t ^ xtime(a1 ^ a2),
			a2 ^ t ^ xtime(a2 ^ a3), a3 ^ t ^ xtime(a3 ^ a0)};
	endfunction

	// Byte datapath: one S-box lookup on the head byte per step, except in the last round
	logic        last_rnd;
	logic [7:0]  head;
	assign last_rnd  = cmd_q ? (round_q == 4'd0) : (round_q == nr);
	assign head   = st_q[127:120];

	// ShiftRows as a fixed permutation of the byte order after the serial pass
	function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inverse);
		logic [127:0] t;
		t = '0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (inverse)
					t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = s[127 - 8*(r + 4*c) -: 8];
				else
					t[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*((c + r) % 4)) -: 8];
			end
		end
		shift_rows = t;
	endfunction

	// The pass of round r adds round key r to each byte and then substitutes it (no S-box on
	// the last round); the mix step does ShiftRows, and MixColumns unless the last round is next.
	logic [7:0] pre_key, pass_byte;
	assign pre_key  = head ^ rk_q[127:120];
	assign pass_byte = last_rnd ? pre_key : (cmd_q ? INV_SBOX[pre_key] : SBOX[pre_key]);

	logic [127:0] sr_state;
	logic [127:0] mixed;
	assign sr_state = shift_rows(st_q, cmd_q);
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			mixed[127 - 32*c -: 32] = cmd_q ? inv_mix_col(sr_state[127 - 32*c -: 32])
				: mix_col(sr_state[127 - 32*c -: 32]);
		end
	end

	// Key schedule word
	logic [7:0] sw_in, sw_out;
	assign sw_in  = tmp_q[31:24];
	assign sw_out = SBOX[sw_in];

	// Round key word address for round r, word w
	logic [5:0] rk_addr;
	assign rk_addr = {round_q, step_q[1:0]};

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Hold the schedule read address through every state of a word step
	assign ek_raddr = (state_q inside {ST_KX_RD, ST_KX_WAIT, ST_KX_WR}) ? (widx_q - {2'b00, nk})
		: (state_q inside {ST_IK_RD, ST_IK_WAIT, ST_IK_WR}) ? widx_q : rk_addr;
	assign dk_raddr = rk_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_length_q <= 2'd0;
			for (int i = 0; i < 4; i++) key_word_q[i] <= 64'd0;
			keys_ready_q <= 1'b0;
			out_valid_q <= 1'b0;
			cmd_q <= CMD_ENCRYPT;
			st_q <= '0;
			rk_q <= '0;
			tmp_q <= '0;
			prev_q <= '0;
			out_q <= '0;
			widx_q <= '0;
			round_q <= '0;
			step_q <= '0;
			rcon_q <= 8'h01;
			kmod_q <= '0;
			bsel_q <= '0;
			ek_we <= 1'b0;
			ek_waddr <= '0;
			ek_wdata <= '0;
			dk_we <= 1'b0;
			dk_waddr <= '0;
			dk_wdata <= '0;
		end else begin
			ek_we <= 1'b0;
			dk_we <= 1'b0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_LENGTH: begin
						key_length_q <= (cfg_data[1:0] == 2'd3) ? 2'd2 : cfg_data[1:0];
						keys_ready_q <= 1'b0;
					end
					REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3: begin
						key_word_q[2'(cfg_index - 3'd1)] <= cfg_data;
						keys_ready_q <= 1'b0;
					end
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= in_data.cmd;
						st_q <= {in_data.block_high, in_data.block_low};
						round_q <= in_data.cmd ? nr : 4'd0;
						step_q <= '0;
						if (keys_ready_q) state_q <= ST_KEY_RD;
						else begin
							widx_q <= '0;
							kmod_q <= '0;
							rcon_q <= 8'h01;
							state_q <= ST_KX_RD;
						end
					end
				end
				// Expand one schedule word: copy a key word or fetch w[i-nk], with byte-serial SubWord where due
				ST_KX_RD: begin
					if (widx_q < {2'b00, nk}) begin
						tmp_q <= widx_q[0] ? key_word_q[widx_q[2:1]][31:0]
							: key_word_q[widx_q[2:1]][63:32];
						bsel_q <= 2'd0;
						state_q <= ST_KX_WR;
					end else begin
						if (kmod_q == 4'd0) tmp_q <= {prev_q[23:0], prev_q[31:24]};
						else tmp_q <= prev_q;
						bsel_q <= 2'd0;
						state_q <= ST_KX_WAIT;
					end
				end
				ST_KX_WAIT: begin
					// Rotate the word through the S-box a byte at a time
					if (kmod_q == 4'd0 || (nk == 4'd8 && kmod_q == 4'd4)) begin
						tmp_q <= {tmp_q[23:0], sw_out};
						bsel_q <= bsel_q + 2'd1;
						if (bsel_q == 2'd3) begin
							state_q <= ST_KX_WR;
						end
					end else begin
						state_q <= ST_KX_WR;
					end
				end
				ST_KX_WR: begin
					logic [31:0] w;
					w = tmp_q;
					if (widx_q >= {2'b00, nk}) begin
						w = tmp_q ^ ek_rdata;
						if (kmod_q == 4'd0) begin
							w = w ^ {rcon_q, 24'd0};
							rcon_q <= xtime(rcon_q);
						end
					end
					ek_we <= 1'b1;
					ek_waddr <= widx_q;
					ek_wdata <= w;
					prev_q <= w;
					kmod_q <= (kmod_q == nk - 4'd1) ? 4'd0 : kmod_q + 4'd1;
					if (widx_q == total - 6'd1) begin
						widx_q <= '0;
						state_q <= ST_IK_RD;
					end else begin
						widx_q <= widx_q + 6'd1;
						state_q <= ST_KX_RD;
					end
				end
				// Decrypt keys: InvMixColumns on the middle rounds, one word at a time
				ST_IK_RD: state_q <= ST_IK_WAIT;
				ST_IK_WAIT: state_q <= ST_IK_WR;
				ST_IK_WR: begin
					dk_we <= 1'b1;
					dk_waddr <= widx_q;
					dk_wdata <= (widx_q[5:2] == 4'd0 || widx_q[5:2] == nr) ? ek_rdata
						: inv_mix_col(ek_rdata);
					if (widx_q == total - 6'd1) begin
						keys_ready_q <= 1'b1;
						state_q <= ST_KEY_RD;
					end else begin
						widx_q <= widx_q + 6'd1;
						state_q <= ST_IK_RD;
					end
					step_q <= '0;
				end
				// Gather the four words of the round key
				ST_KEY_RD: state_q <= ST_KEY_WAIT;
				ST_KEY_WAIT: begin
					rk_q <= {rk_q[95:0], cmd_q ? dk_rdata : ek_rdata};
					if (step_q[1:0] == 2'd3) begin
						step_q <= '0;
						state_q <= ST_BYTE;
					end else begin
						step_q <= step_q + 5'd1;
						state_q <= ST_KEY_RD;
					end
				end
				ST_BYTE: begin
					st_q <= {st_q[119:0], pass_byte};
					rk_q <= {rk_q[119:0], 8'h00};
					if (step_q == 5'd15) begin
						step_q <= '0;
						state_q <= last_rnd ? ST_DONE : ST_MIX;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_MIX: begin
					// Last pass before the final key skips the mix
					if ((cmd_q && round_q == 4'd1) || (!cmd_q && round_q == nr - 4'd1))
						st_q <= sr_state;
					else
						st_q <= mixed;
					round_q <= cmd_q ? round_q - 4'd1 : round_q + 4'd1;
					state_q <= ST_KEY_RD;
				end
				ST_DONE: begin
					out_q <= st_q;
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer accepted while busy");
	a_done_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside completion");

endmodule

[test/tb_top.sv]
// Testbench for the AES block cipher: directed vectors, single register writes, then random blocks and key settings.
`timescale 1ns / 1ps
module tb_top;
	import aes_pkg::*;

	localparam int CycleLimit = 8000000;
	localparam int SettleCycles = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	aes_block_cipher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// cipher state mirrored in the testbench
	logic [1:0] key_len_q;
	logic [63:0] key_q [4];
	logic [31:0] sched [60];
	out_item_t cipher_results [$];
	int errors = 0;
	int cycles = 0;
	bit hold_out = 1'b0;

	function automatic logic [7:0] mul2(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r ^= a;
			a = mul2(a);
		end
		return r;
	endfunction

	function automatic logic [7:0] gf_inv(input logic [7:0] a);
		logic [7:0] r;
		r = 8'h01;
		// a^254 by repeated multiply; zero stays zero
		for (int i = 0; i < 254; i++) r = gf_mul(r, a);
		return (a == 8'h00) ? 8'h00 : r;
	endfunction

	function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
		return (x << n) | (x >> (8 - n));
	endfunction

	logic [7:0] fwd_sub [256];
	logic [7:0] rev_sub [256];

	initial begin
		logic [7:0] y;
		for (int i = 0; i < 256; i++) begin
			y = gf_inv(8'(i));
			fwd_sub[i] = y ^ rotl(y, 1) ^ rotl(y, 2) ^ rotl(y, 3) ^ rotl(y, 4) ^ 8'h63;
		end
		for (int i = 0; i < 256; i++) rev_sub[fwd_sub[i]] = 8'(i);
	end

	function automatic int words_in_key();
		return (key_len_q >= 2) ? 8 : 4 + 2 * key_len_q;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
	endfunction

	function automatic void expand_schedule();
		int nk;
		logic [31:0] t;
		logic [7:0] rc;
		nk = words_in_key();
		rc = 8'h01;
		for (int i = 0; i < nk; i++)
			sched[i] = i[0] ? key_q[i >> 1][31:0] : key_q[i >> 1][63:32];
		for (int i = nk; i < 4 * (nk + 7); i++) begin
			t = sched[i - 1];
			if (i % nk == 0) begin
				t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = mul2(rc);
			end else if (nk > 6 && i % nk == 4) begin
				t = sub_word(t);
			end
			sched[i] = t ^ sched[i - nk];
		end
	endfunction

	typedef logic [7:0] state_t [16];

	function automatic void mix_cols(ref state_t s, input bit inverse);
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
			if (inverse) begin
				s[4*c]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
					^ gf_mul(a3, 8'd9);
				s[4*c+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
					^ gf_mul(a3, 8'd13);
				s[4*c+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
					^ gf_mul(a3, 8'd11);
				s[4*c+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
					^ gf_mul(a3, 8'd14);
			end else begin
				s[4*c]   = gf_mul(a0, 8'd2) ^ gf_mul(a1, 8'd3) ^ a2 ^ a3;
				s[4*c+1] = a0 ^ gf_mul(a1, 8'd2) ^ gf_mul(a2, 8'd3) ^ a3;
				s[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 8'd2) ^ gf_mul(a3, 8'd3);
				s[4*c+3] = gf_mul(a0, 8'd3) ^ a1 ^ a2 ^ gf_mul(a3, 8'd2);
			end
		end
	endfunction

	// decrypt keys: encrypt keys with InvMixColumns on all but the outer rounds
	function automatic void add_round_key(ref state_t s, input int round, input bit dec,
			input int nr);
		state_t k;
		for (int b = 0; b < 16; b++) k[b] = 8'(sched[4*round + b/4] >> (24 - 8*(b%4)));
		if (dec && round != 0 && round != nr) mix_cols(k, 1'b1);
		for (int b = 0; b < 16; b++) s[b] ^= k[b];
	endfunction

	function automatic void sub_shift(ref state_t s, input bit inverse);
		state_t t;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				if (inverse) t[r + 4*((c + r) % 4)] = rev_sub[s[r + 4*c]];
				else t[r + 4*c] = fwd_sub[s[r + 4*((c + r) % 4)]];
		s = t;
	endfunction

	function automatic out_item_t cipher_block(input in_item_t it);
		state_t s;
		int nr;
		out_item_t o;
		nr = words_in_key() + 6;
		for (int b = 0; b < 8; b++) begin
			s[b] = 8'(it.block_high >> (56 - 8*b));
			s[b+8] = 8'(it.block_low >> (56 - 8*b));
		end
		if (it.cmd == CMD_ENCRYPT) begin
			add_round_key(s, 0, 1'b0, nr);
			for (int r = 1; r < nr; r++) begin
				sub_shift(s, 1'b0);
				mix_cols(s, 1'b0);
				add_round_key(s, r, 1'b0, nr);
			end
			sub_shift(s, 1'b0);
			add_round_key(s, nr, 1'b0, nr);
		end else begin
			add_round_key(s, nr, 1'b1, nr);
			for (int r = nr - 1; r > 0; r--) begin
				sub_shift(s, 1'b1);
				mix_cols(s, 1'b1);
				add_round_key(s, r, 1'b1, nr);
			end
			sub_shift(s, 1'b1);
			add_round_key(s, 0, 1'b1, nr);
		end
		for (int b = 0; b < 8; b++) begin
			o.result_high[63 - 8*b -: 8] = s[b];
			o.result_low[63 - 8*b -: 8] = s[b+8];
		end
		return o;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_KEY_LENGTH) key_len_q = value[1:0];
		else key_q[idx - 1] = value;
		expand_schedule();
	endtask

	task automatic drain();
		while (cipher_results.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_key(input logic [1:0] len, input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3);
		drain();
		write_reg(REG_KEY_LENGTH, {62'h0, len});
		write_reg(REG_KEY_WORD_0, k0);
		write_reg(REG_KEY_WORD_1, k1);
		write_reg(REG_KEY_WORD_2, k2);
		write_reg(REG_KEY_WORD_3, k3);
	endtask

	task automatic send_block(input logic cmd, input logic [63:0] hi, input logic [63:0] lo,
			input bit idle);
		in_item_t it;
		it.cmd = cmd;
		it.block_high = hi;
		it.block_low = lo;
		if (idle) repeat (gap_len()) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		cipher_results.push_back(cipher_block(it));
		in_valid <= 1'b0;
		// drop valid before the next transfer can start
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// published test vectors and field extremes
	task automatic test_directed();
		set_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0);
		send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
		send_block(CMD_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
		send_block(CMD_ENCRYPT, '0, '0, 1'b0);
		send_block(CMD_DECRYPT, '1, '1, 1'b0);
		set_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
			64'h0);
		send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
		send_block(CMD_DECRYPT, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1'b0);
		set_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h18191a1b1c1d1e1f);
		send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
		send_block(CMD_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b0);
		// unused length code acts as a 256-bit key
		set_key(2'd3, '1, '1, '1, '1);
		send_block(CMD_ENCRYPT, '1, '0, 1'b0);
		send_block(CMD_DECRYPT, '0, '1, 1'b0);
		set_key(2'd0, '0, '0, '0, '0);
		send_block(CMD_ENCRYPT, '0, '0, 1'b0);
		send_block(CMD_DECRYPT, '1, '1, 1'b0);
	endtask

	// random blocks in phases, each under a fresh key setting
	task automatic test_random(input int count);
		logic [1:0] len;
		for (int p = 0; p < 12; p++) begin
			len = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
			set_key(len, rand64(), rand64(), rand64(), rand64());
			for (int i = 0; i < count / 12; i++)
				send_block(1'($urandom), rand64(), rand64(), (p % 3) != 0);
			// hold the sender until every result is back
			while (cipher_results.size() != 0) @(posedge clk);
		end
	endtask

	// one register changed at a time, then blocks reuse the new schedule
	task automatic test_single_writes();
		for (int i = 0; i < 10; i++) begin
			drain();
			if (i % 5 == 0) write_reg(REG_KEY_LENGTH, {62'h0, 2'($urandom)});
			else write_reg(reg_index_t'(i % 5), rand64());
			repeat (4) send_block(1'($urandom), rand64(), rand64(), 1'b1);
		end
	endtask

	always @(posedge clk) begin
		if (hold_out) out_ready <= 1'b0;
		else if ($urandom_range(0, 99) < 70) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 9) == 0) ? 1'b1 : 1'b0;
	end

	// long receiver stalls now and then
	initial begin
		forever begin
			repeat ($urandom_range(200, 3000)) @(posedge clk);
			hold_out = 1'b1;
			repeat ($urandom_range(5, 80)) @(posedge clk);
			hold_out = 1'b0;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (cipher_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				want = cipher_results.pop_front();
				if (out_data.result_high !== want.result_high) begin
					$display("%0t: result_high expected %h actual %h", $time,
						want.result_high, out_data.result_high);
					errors++;
				end
				if (out_data.result_low !== want.result_low) begin
					$display("%0t: result_low expected %h actual %h", $time,
						want.result_low, out_data.result_low);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		key_len_q = 2'd0;
		for (int i = 0; i < 4; i++) key_q[i] = '0;
		expand_schedule();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_single_writes();
		test_random(1740);
		drain();
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule

[aes_block_cipher.f]
hdl/aes_pkg.sv
hdl/aes_ram.sv
hdl/aes_block_cipher.sv
test/tb_top.sv
